FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// condition must never occur out of reset
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)

`endif

`endif

FILE: sv/annexb_pkg.sv
// ----------------------------------------------------------------------------
// annexb_pkg
// Constants and types of the Annex B start code splitter.
// ----------------------------------------------------------------------------
package annexb_pkg;

  // delay window depth and prefix lengths
  localparam int WinDepth    = 4;
  localparam int ShortPrefix = 3;
  localparam int LongPrefix  = 4;

  localparam int ByteW  = 8;
  localparam int PlenW  = 3;
  localparam int GuardW = $clog2(WinDepth + 1);

  // one entry of the delay window
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             valid;
    logic             start_mark;
    logic             long_pfx;
    logic             end_mark;
  } win_entry_t;

endpackage

FILE: sv/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex B byte stream into units at 00 00 01 / 00 00 00 01
// start codes and marks the first and last byte of every unit.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, data_byte_i            | sink
//  out     | out_valid_o, out_stall_i, out_byte_o,          | source
//          | unit_start_o, prefix_len_o, unit_end_o         |
//
// One byte is accepted per clock while in_stall_o is low; the work is the
// window shift plus the start code compare, done between the window registers
// and the out register. A byte leaves the window when the fourth byte after
// it is accepted and is loaded into the out register at that edge (window lag).
// rst_ni clears the window, the unit flag and the fill guard; bytes before
// the first start code are dropped. The last unit stays open (no flush).
// in_stall_o rises only while a word sits in the out register and out_stall_i
// is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_unit_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [annexb_pkg::ByteW-1:0]  data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [annexb_pkg::ByteW-1:0]  out_byte_o,
  output logic                          unit_start_o,
  output logic [annexb_pkg::PlenW-1:0]  prefix_len_o,
  output logic                          unit_end_o
);

  annexb_pkg::win_entry_t               win_q [annexb_pkg::WinDepth];
  annexb_pkg::win_entry_t               win_s [annexb_pkg::WinDepth];
  annexb_pkg::win_entry_t               win_d [annexb_pkg::WinDepth];
  annexb_pkg::win_entry_t               ev;
  logic                                 inside_q, inside_d;
  logic [annexb_pkg::GuardW-1:0]        guard_q, guard_d;
  logic                                 found, found_long, ev_end;
  logic                                 in_acc;
  logic                                 out_valid_q, out_valid_d;
  logic [annexb_pkg::ByteW-1:0]         out_byte_q;
  logic                                 unit_start_q, unit_end_q;
  logic [annexb_pkg::PlenW-1:0]         prefix_len_q, plen_d;

  // handshake: take a word whenever the out register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // window shift, start code detection and marking
  always_comb begin
    ev = win_q[0];
    for (int i = 0; i < annexb_pkg::WinDepth - 1; i++) begin
      win_s[i] = win_q[i+1];
    end
    win_s[annexb_pkg::WinDepth-1]            = '0;
    win_s[annexb_pkg::WinDepth-1].data       = data_byte_i;
    win_s[annexb_pkg::WinDepth-1].valid      = inside_q;

    guard_d = (guard_q < annexb_pkg::GuardW'(annexb_pkg::WinDepth)) ?
              guard_q + annexb_pkg::GuardW'(1) : guard_q;

    found = (guard_d >= annexb_pkg::GuardW'(annexb_pkg::ShortPrefix)) &&
            (win_s[1].data == '0) && (win_s[2].data == '0) &&
            (win_s[3].data == annexb_pkg::ByteW'(1));
    found_long = found &&
                 (guard_d >= annexb_pkg::GuardW'(annexb_pkg::LongPrefix)) &&
                 (win_s[0].data == '0);

    win_d  = win_s;
    ev_end = ev.end_mark;
    if (found_long) begin
      // four-byte prefix fills the whole window, evicted byte closes the unit
      for (int i = 0; i < annexb_pkg::WinDepth; i++) begin
        win_d[i].valid      = 1'b1;
        win_d[i].start_mark = 1'b0;
        win_d[i].long_pfx   = 1'b0;
        win_d[i].end_mark   = 1'b0;
      end
      win_d[0].start_mark = 1'b1;
      win_d[0].long_pfx   = 1'b1;
      ev_end              = 1'b1;
    end else if (found) begin
      // three-byte prefix, oldest window byte closes the unit
      for (int i = 1; i < annexb_pkg::WinDepth; i++) begin
        win_d[i].valid      = 1'b1;
        win_d[i].start_mark = 1'b0;
        win_d[i].long_pfx   = 1'b0;
        win_d[i].end_mark   = 1'b0;
      end
      win_d[1].start_mark = 1'b1;
      if (win_s[0].valid) begin
        win_d[0].end_mark = 1'b1;
      end
    end

    inside_d = inside_q | found;

    if (!ev.start_mark) begin
      plen_d = '0;
    end else if (ev.long_pfx) begin
      plen_d = annexb_pkg::PlenW'(annexb_pkg::LongPrefix);
    end else begin
      plen_d = annexb_pkg::PlenW'(annexb_pkg::ShortPrefix);
    end
  end

  // out register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = ev.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < annexb_pkg::WinDepth; i++) begin
        win_q[i] <= '0;
      end
      inside_q    <= 1'b0;
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        win_q    <= win_d;
        inside_q <= inside_d;
        guard_q  <= guard_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // out payload
  always_ff @(posedge clk_i) begin
    if (in_acc && ev.valid) begin
      out_byte_q   <= ev.data;
      unit_start_q <= ev.start_mark;
      prefix_len_q <= plen_d;
      unit_end_q   <= ev_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign unit_start_o = unit_start_q;
  assign prefix_len_o = prefix_len_q;
  assign unit_end_o   = unit_end_q;

  // valid entries always form a run up to the newest entry
  `ASSERT_AT(a_valid_run, clk_i, rst_ni,
    (!win_q[0].valid || win_q[1].valid) && (!win_q[1].valid || win_q[2].valid) &&
    (!win_q[2].valid || win_q[3].valid))
  // a start mark only sits on a byte that will be put out
  `ASSERT_NEVER(a_start_unowned, clk_i, rst_ni,
    (win_q[0].start_mark && !win_q[0].valid) || (win_q[1].start_mark && !win_q[1].valid))
  // the fill guard saturates at the window depth
  `ASSERT_AT(a_guard_sat, clk_i, rst_ni,
    guard_q <= annexb_pkg::GuardW'(annexb_pkg::WinDepth))
  // once inside a unit the block never leaves it
  `ASSERT_NEVER(a_inside_drop, clk_i, rst_ni, $fell(inside_q))
  // a unit's first byte carries a three- or four-byte prefix length
  `ASSERT_AT(a_plen_start, clk_i, rst_ni,
    !out_valid_o || (unit_start_o == (prefix_len_o != '0)))

endmodule

FILE: bench/tb_annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_annexb_nal_unit_splitter
// Feeds byte streams with 3- and 4-byte start codes, zero runs, broken codes
// and noise into the splitter. A window predictor computes the expected out
// words, which are checked field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_annexb_nal_unit_splitter;

  localparam int DirLen    = 24;
  localparam int RandBytes = 826;
  localparam int CycLimit  = 500000;

  // one out word of the splitter
  typedef struct packed {
    logic [annexb_pkg::ByteW-1:0] data;
    logic                         start;
    logic [annexb_pkg::PlenW-1:0] plen;
    logic                         last;
  } nal_word_t;

  // directed stream byte with the word it should push out (if any)
  typedef struct {
    logic [annexb_pkg::ByteW-1:0] b;
    bit                           has;
    logic [annexb_pkg::ByteW-1:0] data;
    logic                         start;
    logic [annexb_pkg::PlenW-1:0] plen;
    logic                         last;
  } dir_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic [annexb_pkg::ByteW-1:0] data_byte_i = '0;
  logic                         out_stall_i = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [annexb_pkg::ByteW-1:0] out_byte_o;
  logic                         unit_start_o;
  logic [annexb_pkg::PlenW-1:0] prefix_len_o;
  logic                         unit_end_o;

  annexb_nal_unit_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .prefix_len_o (prefix_len_o),
    .unit_end_o   (unit_end_o)
  );

  // start right after reset, a long code, a long zero run, a short code
  // that closes a unit on its own byte
  dir_row_t dir_tab [DirLen] = '{
    '{8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h01, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'hff, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h80, 1'b1, 8'h00, 1'b1, 3'd3, 1'b0},
    '{8'h7f, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'h01, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'hff, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'h80, 1'b0, 3'd0, 1'b0},
    '{8'h01, 1'b1, 8'h7f, 1'b0, 3'd0, 1'b1},
    '{8'haa, 1'b1, 8'h00, 1'b1, 3'd4, 1'b0},
    '{8'h00, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'h01, 1'b0, 3'd0, 1'b0},
    '{8'h00, 1'b1, 8'haa, 1'b0, 3'd0, 1'b0},
    '{8'h01, 1'b1, 8'h00, 1'b0, 3'd0, 1'b1},
    '{8'h00, 1'b1, 8'h00, 1'b1, 3'd4, 1'b0},
    '{8'h00, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h01, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'h42, 1'b1, 8'h01, 1'b0, 3'd0, 1'b1},
    '{8'hff, 1'b1, 8'h00, 1'b1, 3'd3, 1'b0},
    '{8'hff, 1'b1, 8'h00, 1'b0, 3'd0, 1'b0},
    '{8'hff, 1'b1, 8'h01, 1'b0, 3'd0, 1'b0},
    '{8'hff, 1'b1, 8'h42, 1'b0, 3'd0, 1'b0}
  };

  // predictor state
  annexb_pkg::win_entry_t win [annexb_pkg::WinDepth];
  bit                     in_unit;
  int                     fill;

  nal_word_t  pending_words [$];
  int         mismatches;
  int         n_in;
  int         cycles;
  bit         sender_calm;
  bit         stall_calm;
  int         stall_left;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // open a prefix at window slot first, everything behind it joins the unit
  function automatic void open_prefix(input int first, input bit is_long);
    for (int i = first; i < annexb_pkg::WinDepth; i++) begin
      win[i].valid      = 1'b1;
      win[i].start_mark = 1'b0;
      win[i].long_pfx   = 1'b0;
      win[i].end_mark   = 1'b0;
    end
    win[first].start_mark = 1'b1;
    win[first].long_pfx   = is_long;
  endfunction

  // shift one byte into the window, return 1 when a word leaves it
  function automatic bit advance_window(input logic [annexb_pkg::ByteW-1:0] b,
                                        output nal_word_t w);
    annexb_pkg::win_entry_t old;
    bit                     found;
    old = win[0];
    for (int i = 0; i < annexb_pkg::WinDepth - 1; i++) win[i] = win[i + 1];
    win[annexb_pkg::WinDepth-1] = '{data: b, valid: in_unit, default: 1'b0};
    if (fill < annexb_pkg::WinDepth) fill++;
    found = fill >= annexb_pkg::ShortPrefix && win[1].data == 8'h00 &&
            win[2].data == 8'h00 && win[3].data == 8'h01;
    if (found) begin
      if (fill >= annexb_pkg::LongPrefix && win[0].data == 8'h00) begin
        open_prefix(0, 1'b1);
        if (old.valid) old.end_mark = 1'b1;
      end else begin
        open_prefix(1, 1'b0);
        if (win[0].valid) win[0].end_mark = 1'b1;
      end
      in_unit = 1'b1;
    end
    w.data  = old.data;
    w.start = old.start_mark;
    w.plen  = !old.start_mark ? annexb_pkg::PlenW'(0) :
              old.long_pfx ? annexb_pkg::PlenW'(annexb_pkg::LongPrefix) :
                             annexb_pkg::PlenW'(annexb_pkg::ShortPrefix);
    w.last  = old.end_mark;
    return old.valid;
  endfunction

  // sender gap: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // present one byte and hold it until it is taken
  task automatic push_byte(input logic [annexb_pkg::ByteW-1:0] b, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // queue up one stream segment: a unit, a broken code, or noise
  task automatic add_segment(ref logic [annexb_pkg::ByteW-1:0] q [$]);
    int r;
    int nz;
    int len;
    int k;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      k  = $urandom_range(0, 9);
      nz = (k < 6) ? 2 : (k < 9) ? 3 : $urandom_range(4, 6);
      repeat (nz) q.push_back(8'h00);
      q.push_back(8'h01);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (len) begin
        k = $urandom_range(0, 9);
        q.push_back(k == 0 ? 8'h00 : k == 1 ? 8'h01 :
                    annexb_pkg::ByteW'($urandom_range(0, 255)));
      end
    end else if (r < 88) begin
      // zeros that never reach a code
      if ($urandom_range(0, 1) != 0) q.push_back(8'h00);
      q.push_back(8'h00);
      q.push_back(annexb_pkg::ByteW'($urandom_range(2, 255)));
      if ($urandom_range(0, 1) != 0) begin
        q.push_back(8'h00);
        q.push_back(8'h01);
        q.push_back(annexb_pkg::ByteW'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        k = $urandom_range(0, 2);
        q.push_back(k == 0 ? 8'h00 : k == 1 ? 8'h01 :
                    annexb_pkg::ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver stall: mostly open, short and long stalls, calm stretches
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_calm <= !stall_calm;
      if (stall_calm || $urandom_range(0, 99) < 70) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 9) != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(8, 25);
      end
    end
  end

  // predict on every accepted byte, check every accepted word
  always @(posedge clk_i) begin
    nal_word_t w;
    nal_word_t exp_w;
    nal_word_t act_w;
    bit        got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        got = advance_window(data_byte_i, w);
        if (got) pending_words.push_back(w);
        if (n_in < DirLen) begin
          exp_w = '{dir_tab[n_in].data, dir_tab[n_in].start, dir_tab[n_in].plen,
                    dir_tab[n_in].last};
          if (got != dir_tab[n_in].has || (got && w != exp_w)) begin
            $display("%0t: directed byte %0d: expected has=%0b word=%h, %s %0b word=%h",
                     $time, n_in, dir_tab[n_in].has, exp_w, "predicted has=", got, w);
            mismatches++;
          end
        end
        n_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        act_w = '{out_byte_o, unit_start_o, prefix_len_o, unit_end_o};
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word: actual byte=%h start=%0b plen=%0d end=%0b",
                   $time, out_byte_o, unit_start_o, prefix_len_o, unit_end_o);
          mismatches++;
        end else begin
          exp_w = pending_words.pop_front();
          if (act_w !== exp_w) begin
            if (act_w.data !== exp_w.data)
              $display("%0t: out_byte: expected %h, actual %h",
                       $time, exp_w.data, act_w.data);
            if (act_w.start !== exp_w.start)
              $display("%0t: unit_start: expected %0b, actual %0b",
                       $time, exp_w.start, act_w.start);
            if (act_w.plen !== exp_w.plen)
              $display("%0t: prefix_len: expected %0d, actual %0d",
                       $time, exp_w.plen, act_w.plen);
            if (act_w.last !== exp_w.last)
              $display("%0t: unit_end: expected %0b, actual %0b",
                       $time, exp_w.last, act_w.last);
            mismatches++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
      $display("** annexb_nal_unit_splitter: FAILED **");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [annexb_pkg::ByteW-1:0] stream_q [$];
    int                           sent;
    for (int i = 0; i < annexb_pkg::WinDepth; i++) win[i] = '0;
    in_unit    = 1'b0;
    fill       = 0;
    mismatches = 0;
    n_in       = 0;
    cycles     = 0;
    stall_left = 0;
    sender_calm = 1'b0;
    stall_calm  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed stream
    for (int i = 0; i < DirLen; i++) push_byte(dir_tab[i].b, pick_gap());

    // random stream
    sent = 0;
    while (sent < RandBytes) begin
      if (sent == RandBytes / 2) begin
        // hold off until the block has drained all it can
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_words.size() != 0) @(posedge clk_i);
      end
      if (stream_q.size() == 0) add_segment(stream_q);
      push_byte(stream_q.pop_front(), pick_gap());
      sent++;
    end
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** annexb_nal_unit_splitter: PASSED **");
    end else begin
      $display("** annexb_nal_unit_splitter: FAILED **");
    end
    $finish;
  end

endmodule
